// File: src/ctpg_pkg.sv
// Shared types, opcodes and constants for the character tile pixel generator.
// No dependencies; compiled first.
package ctpg_pkg;

	localparam int TILE_AW = 10;
	localparam int PAT_AW  = 11;
	localparam int PROM_AW = 5;
	localparam int APB_AW  = 3;
	localparam int REG_IW  = APB_AW - 2;

	localparam logic [REG_IW-1:0] REG_COLOR_MODE = '0;
	localparam logic              COLOR_MODE_RST = 1'b1;

	typedef enum logic [2:0] {
		OP_TILE_WR = 3'd0,
		OP_PAT_WR  = 3'd1,
		OP_PROM_WR = 3'd2,
		OP_PAL_WR  = 3'd3,
		OP_PIXEL   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TILE,
		ST_PAT
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [10:0] address;
		logic [7:0]  data;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_rgb;
		logic [7:0]  out_x;
		logic [7:0]  out_y;
	} out_item_t;

	// 3-bit color index: bit2 red, bit0 green, bit1 blue, full intensity
	function automatic logic [23:0] rgb_of_index(input logic [2:0] idx);
		rgb_of_index = {{8{idx[2]}}, {8{idx[0]}}, {8{idx[1]}}};
	endfunction

endpackage

// File: src/ctpg_if.sv
// Valid/ready channels for request items and pixel items.
// Depends on ctpg_pkg.
interface ctpg_in_if;
	logic               valid;
	logic               ready;
	ctpg_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface ctpg_out_if;
	logic                valid;
	logic                ready;
	ctpg_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// File: src/char_tile_pixel_generator.sv
// Character tile pixel generator: tile RAM, pattern RAM, color PROM, palette bank.
// Depends on ctpg_pkg and the channel interfaces in ctpg_if.sv.
// Usage: write items (tile, pattern, PROM, palette bank) are accepted only in the idle
// state and give no result. A pixel request runs in steps: the tile code RAM read, then
// the pattern RAM and color PROM reads in parallel, then forming the color into the
// output register, which waits while that register still holds an untaken pixel. The
// block handles one item at a time; the output register lets the next item enter while
// a pixel waits to be taken. Tile, pattern and PROM entries must be written before a pixel reads them.
// color_mode (register 0, reset 1) picks PROM colors or black and white.
module char_tile_pixel_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ctpg_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	ctpg_in_if.sink                     pix_in,
	ctpg_out_if.source                  pix_out
);
	import ctpg_pkg::*;

	logic [7:0] tile_mem [1 << TILE_AW];
	logic [7:0] pat_mem  [1 << PAT_AW];
	logic [7:0] prom_mem [1 << PROM_AW];

	state_t      state_q, state_d;
	logic        color_mode_q;
	logic [1:0]  pal_q;
	logic [7:0]  px_q, py_q;
	logic [7:0]  tile_s1;
	logic [7:0]  pat_s2, prom_s2;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_ready, in_acc, pix_start, out_load;
	logic        pix_bit;
	logic [23:0] rgb;
	logic        cfg_wr;
	op_t         op;

	assign op     = op_t'(pix_in.item.operation);
	assign in_acc = pix_in.valid && in_ready;

	assign pix_in.ready  = in_ready;
	assign pix_out.valid = out_valid_q;
	assign pix_out.item  = out_q;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[APB_AW-1:2] == REG_COLOR_MODE) ? {31'd0, color_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= COLOR_MODE_RST;
		end else if (cfg_wr && paddr[APB_AW-1:2] == REG_COLOR_MODE) begin
			color_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		pix_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (pix_in.valid && op == OP_PIXEL) begin
					pix_start = 1'b1;
					state_d   = ST_TILE;
				end
			end
			ST_TILE: begin
				state_d = ST_PAT;
			end
			ST_PAT: begin
				if (!out_valid_q || pix_out.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pal_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && op == OP_PAL_WR) begin
				pal_q <= pix_in.item.data[1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (in_acc && op == OP_TILE_WR) begin
			tile_mem[pix_in.item.address[TILE_AW-1:0]] <= pix_in.item.data;
		end
		if (pix_start) begin
			tile_s1 <= tile_mem[{pix_in.item.pixel_y[7:3], pix_in.item.pixel_x[7:3]}];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_PAT_WR) begin
			pat_mem[pix_in.item.address[PAT_AW-1:0]] <= pix_in.item.data;
		end
		if (state_q == ST_TILE) begin
			pat_s2 <= pat_mem[{tile_s1, py_q[2:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_PROM_WR) begin
			prom_mem[pix_in.item.address[PROM_AW-1:0]] <= pix_in.item.data;
		end
		if (state_q == ST_TILE) begin
			prom_s2 <= prom_mem[{pal_q, tile_s1[7:5]}];
		end
	end

	always_ff @(posedge clk) begin
		if (pix_start) begin
			px_q <= pix_in.item.pixel_x;
			py_q <= pix_in.item.pixel_y;
		end
	end

	// bit 7 is the leftmost pixel of a line
	assign pix_bit = pat_s2[~px_q[2:0]];

	always_comb begin
		if (color_mode_q) begin
			rgb = pix_bit ? rgb_of_index(prom_s2[7:5]) : rgb_of_index(prom_s2[3:1]);
		end else begin
			rgb = {24{pix_bit}};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pixel_rgb <= rgb;
			out_q.out_x     <= px_q;
			out_q.out_y     <= py_q;
		end
	end

endmodule
